@@ rtl/tmra_pkg.sv @@
// shared constants for the trimmed mean rolling average block
`default_nettype none

package tmra_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SPB_DEF = 10;
	localparam int HD_DEF = 10;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

endpackage

`default_nettype wire

@@ rtl/tmra_acc.sv @@
// block accumulator: running sum, minimum, maximum and sample count
`default_nettype none

module tmra_acc
	import tmra_pkg::*;
#(
	parameter int SAMPLES_PER_BLOCK = SPB_DEF,
	parameter int SUM_W = SAMPLE_W + $clog2(SPB_DEF)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [SAMPLE_W-1:0] sample,
	output logic                     at_last,
	output logic [SUM_W-1:0]         rest
);

	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_nx;
	logic [SAMPLE_W-1:0] min_nx;
	logic [SAMPLE_W-1:0] max_nx;

	// values including the incoming sample
	always_comb begin
		sum_nx = sum_q + SUM_W'(sample);
		min_nx = (sample < min_q) ? sample : min_q;
		max_nx = (sample > max_q) ? sample : max_q;
		rest = sum_nx - SUM_W'(min_nx) - SUM_W'(max_nx);
	end

	assign at_last = (cnt_q == CNT_LAST);

	// accumulators restart after the last sample of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= SAMPLE_MAX;
			max_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (at_last) begin
				sum_q <= '0;
				min_q <= SAMPLE_MAX;
				max_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				min_q <= min_nx;
				max_q <= max_nx;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tmra_cdiv.sv @@
// division by a constant through a registered reciprocal multiply
`default_nettype none

module tmra_cdiv #(
	parameter int XW = 18,
	parameter int QW = 12,
	parameter int DIV = 8
) (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire logic [XW-1:0] x,
	output logic [QW-1:0]      q
);

	// ceil(2^SHIFT / DIV) is exact for every x below 2^XW
	localparam int SHIFT = XW + $clog2(DIV);
	localparam int MW = XW + 2;
	localparam int PW = XW + MW;
	localparam logic [MW-1:0] MULT =
		MW'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));

	logic [PW-1:0] prod_q;

	// product register
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PW'(x) * PW'(MULT);
		end
	end

	assign q = prod_q[SHIFT +: QW];

endmodule

`default_nettype wire

@@ rtl/tmra_cell.sv @@
// one history cell: holds a block mean and passes it to the next cell
`default_nettype none

module tmra_cell
	import tmra_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic [SAMPLE_W-1:0] d,
	output logic [SAMPLE_W-1:0]      q
);

	logic [SAMPLE_W-1:0] val_q;

	// history entries start at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

`default_nettype wire

@@ rtl/trimmed_mean_rolling_average.sv @@
// Trimmed mean block filter with a moving average over the last block means.
// One sample is taken per clock while input ready is high. After every
// SAMPLES_PER_BLOCK samples the sum less one minimum and one maximum is
// divided by SAMPLES_PER_BLOCK - 2, the mean shifts into a chain of
// HISTORY_DEPTH cells (zero after reset), and one result carries the chain
// average and the block mean. The pipeline from the last sample of a block
// to the output is the accumulator, a reciprocal multiply for the block mean,
// the cell chain with its running sum, a reciprocal multiply for the average
// and the output register. Input ready drops only on the last sample of a
// block while the first stage is held by output back pressure.
`default_nettype none

module trimmed_mean_rolling_average
	import tmra_pkg::*;
#(
	parameter int SAMPLES_PER_BLOCK = SPB_DEF,
	parameter int HISTORY_DEPTH = HD_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [11:0] sample
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [11:0] filtered_average, [23:12] block_mean
	output logic [M_TDATA_W-1:0]      m_tdata
);

	localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_BLOCK);
	localparam int HSUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);

	logic                take;
	logic                at_last;
	logic [SUM_W-1:0]    rest;
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SUM_W-1:0]    rest_s1;
	logic [SAMPLE_W-1:0] mean;
	logic [SAMPLE_W-1:0] mean_s3, mean_s4;
	logic [HSUM_W-1:0]   hsum_q;
	logic [HSUM_W-1:0]   hsum_nx;
	logic [HSUM_W-1:0]   hsum_s3;
	logic [SAMPLE_W-1:0] avg;
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] avg_q, mean_q;
	logic                ld1, ld2, ld3, ld4, ld_out;
	logic                free1, free2, free3, free4;
	logic [SAMPLE_W-1:0] cell_q [HISTORY_DEPTH];

	// stage advance, each stage moves when the one after it has room
	always_comb begin
		ld_out = valid_s4 && (!m_tvalid_q || m_tready);
		free4 = !valid_s4 || ld_out;
		ld4 = valid_s3 && free4;
		free3 = !valid_s3 || ld4;
		ld3 = valid_s2 && free3;
		free2 = !valid_s2 || ld3;
		ld2 = valid_s1 && free2;
		free1 = !valid_s1 || ld2;
	end

	assign s_tready = !at_last || free1;
	assign take = s_tvalid && s_tready;
	assign ld1 = take && at_last;

	tmra_acc #(
		.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
		.SUM_W(SUM_W)
	) u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.sample(s_tdata[SAMPLE_W-1:0]),
		.at_last(at_last),
		.rest(rest)
	);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ld1 || ld2) valid_s1 <= ld1;
			if (ld2 || ld3) valid_s2 <= ld2;
			if (ld3 || ld4) valid_s3 <= ld3;
			if (ld4 || ld_out) valid_s4 <= ld4;
			if (ld_out || m_tready) m_tvalid_q <= ld_out;
		end
	end

	// trimmed block sum
	always_ff @(posedge clk) begin
		if (ld1) begin
			rest_s1 <= rest;
		end
	end

	tmra_cdiv #(
		.XW(SUM_W),
		.QW(SAMPLE_W),
		.DIV(SAMPLES_PER_BLOCK - 2)
	) u_mean_div (
		.clk(clk),
		.load(ld2),
		.x(rest_s1),
		.q(mean)
	);

	// history chain, the oldest mean drops out of the last cell
	generate
		for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
			tmra_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ld3),
				.d((i == 0) ? mean : cell_q[(i == 0) ? 0 : i - 1]),
				.q(cell_q[i])
			);
		end
	endgenerate

	assign hsum_nx = hsum_q - HSUM_W'(cell_q[HISTORY_DEPTH-1]) + HSUM_W'(mean);

	// running sum of all cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= '0;
		end else if (ld3) begin
			hsum_q <= hsum_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			hsum_s3 <= hsum_nx;
			mean_s3 <= mean;
		end
	end

	tmra_cdiv #(
		.XW(HSUM_W),
		.QW(SAMPLE_W),
		.DIV(HISTORY_DEPTH)
	) u_avg_div (
		.clk(clk),
		.load(ld4),
		.x(hsum_s3),
		.q(avg)
	);

	always_ff @(posedge clk) begin
		if (ld4) begin
			mean_s4 <= mean_s3;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			avg_q <= avg;
			mean_q <= mean_s4;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {mean_q, avg_q};

endmodule

`default_nettype wire

@@ rtl/tmra_chk.sv @@
// port checker for the trimmed mean rolling average block, with its bind
`default_nettype none

module tmra_chk
	import tmra_pkg::*;
#(
	parameter int SAMPLES_PER_BLOCK = SPB_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [S_TDATA_W-1:0] s_tdata,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);

	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       pend_q;
	logic             in_xact, out_xact, blk_done;

	assign in_xact = s_tvalid && s_tready;
	assign out_xact = m_tvalid && m_tready;
	assign blk_done = in_xact && (cnt_q == CNT_LAST);

	// completed blocks whose results are not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (in_xact) cnt_q <= blk_done ? '0 : cnt_q + 1'b1;
			pend_q <= pend_q + 3'(blk_done) - 3'(out_xact);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result without a completed block");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd5)
		else $error("more results pending than pipeline depth");

	a_ready_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && pend_q == 3'd1 |-> s_tready)
		else $error("input stalled behind a single waiting result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// an offered sample stays put until the block takes it
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("stalled sample changed");

endmodule

bind trimmed_mean_rolling_average tmra_chk #(
	.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
) u_tmra_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata(s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the trimmed mean rolling average block: directed and random samples, checked
// against a cycle-free predictor of the block means and the rolling history average
`default_nettype none

module tb_top;
	import tmra_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered_average;
		logic [SAMPLE_W-1:0] block_mean;
	} block_result_t;

	typedef enum int {
		BLK_UNIFORM,
		BLK_FLAT,
		BLK_NARROW,
		BLK_OUTLIER,
		BLK_RAIL
	} block_kind_e;

	localparam int RANDOM_BLOCKS = 38;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_WAIT = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// samples waiting to be sent and block results waiting to arrive
	logic [SAMPLE_W-1:0] sample_q[$];
	block_result_t       block_result_q[$];

	// predictor state
	logic [17:0]         acc_sum = '0;
	logic [SAMPLE_W-1:0] acc_min = SAMPLE_MAX;
	logic [SAMPLE_W-1:0] acc_max = '0;
	logic [5:0]          acc_count = '0;
	logic [SAMPLE_W-1:0] ring[0:15];
	logic [3:0]          ring_ptr = '0;
	logic [15:0]         ring_sum = '0;

	int errors = 0;
	int samples_taken = 0;
	int results_checked = 0;
	int ring_wraps = 0;

	// handshake pacing
	int  tx_gap = 0;
	bit  tx_calm = 1'b0;
	int  tx_stretch = 0;
	int  rx_gap = 0;
	bit  rx_calm = 1'b0;
	int  rx_stretch = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	trimmed_mean_rolling_average #(
		.SAMPLES_PER_BLOCK(SPB_DEF),
		.HISTORY_DEPTH(HD_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// wait before the next transaction: stretches of back-to-back traffic alternate with idling
	function automatic int draw_wait(inout bit calm, inout int stretch);
		if (stretch == 0) begin
			calm = ($urandom_range(0, 2) == 0);
			stretch = $urandom_range(8, 40);
		end
		stretch--;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void clear_block_acc();
		acc_sum = '0;
		acc_min = SAMPLE_MAX;
		acc_max = '0;
		acc_count = '0;
	endfunction

	// fold one sample into the block; a full block yields its trimmed mean and ring average
	function automatic void predict_sample(input logic [SAMPLE_W-1:0] s);
		logic [17:0]         rest;
		logic [SAMPLE_W-1:0] mean;
		block_result_t       r;
		acc_sum = acc_sum + s;
		if (s < acc_min)
			acc_min = s;
		if (s > acc_max)
			acc_max = s;
		if (acc_count + 1 < SPB_DEF) begin
			acc_count = acc_count + 1'b1;
			return;
		end
		rest = acc_sum - acc_min - acc_max;
		mean = SAMPLE_W'(rest / (SPB_DEF - 2));
		ring_sum = ring_sum - ring[ring_ptr] + mean;
		ring[ring_ptr] = mean;
		if (ring_ptr + 1 >= HD_DEF) begin
			ring_ptr = '0;
			ring_wraps++;
		end else begin
			ring_ptr = ring_ptr + 1'b1;
		end
		r.filtered_average = SAMPLE_W'(ring_sum / HD_DEF);
		r.block_mean = mean;
		block_result_q.push_back(r);
		clear_block_acc();
	endfunction

	// sample driver: predicts on every accepted transaction, then offers the next sample
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap = 0;
			clear_block_acc();
			for (int i = 0; i < 16; i++)
				ring[i] = '0;
			ring_ptr = '0;
			ring_sum = '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_sample(s_tdata[SAMPLE_W-1:0]);
				samples_taken <= samples_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s_tdata <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, sample_q.pop_front()};
					s_tvalid <= 1'b1;
					tx_gap = draw_wait(tx_calm, tx_stretch);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long output stall once traffic is under way, so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && samples_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor: compares each accepted transaction with the oldest expected result
	always @(posedge clk or negedge arst_n) begin
		block_result_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (block_result_q.size() == 0) begin
					$error("unexpected result: filtered_average %0d block_mean %0d",
						m_tdata[11:0], m_tdata[23:12]);
					errors++;
				end else begin
					exp_r = block_result_q.pop_front();
					if (m_tdata[11:0] !== exp_r.filtered_average) begin
						$error("filtered_average: expected %0d, got %0d",
							exp_r.filtered_average, m_tdata[11:0]);
						errors++;
					end
					if (m_tdata[23:12] !== exp_r.block_mean) begin
						$error("block_mean: expected %0d, got %0d",
							exp_r.block_mean, m_tdata[23:12]);
						errors++;
					end
				end
				results_checked++;
				rx_gap = draw_wait(rx_calm, rx_stretch);
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		block_kind_e kind;
		int          base;
		int          v;
		// flat block at full scale: min and max coincide
		repeat (SPB_DEF)
			sample_q.push_back(SAMPLE_MAX);
		// both rails, single bits and alternating patterns
		sample_q.push_back(12'd0);
		sample_q.push_back(12'd4095);
		sample_q.push_back(12'd0);
		sample_q.push_back(12'd4095);
		sample_q.push_back(12'd2048);
		sample_q.push_back(12'd1);
		sample_q.push_back(12'd4094);
		sample_q.push_back(12'h555);
		sample_q.push_back(12'hAAA);
		sample_q.push_back(12'd2047);
		// random blocks of several shapes; enough of them to wrap the history ring a few times
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			kind = block_kind_e'($urandom_range(BLK_UNIFORM, BLK_RAIL));
			base = $urandom_range(0, 4095);
			for (int k = 0; k < SPB_DEF; k++) begin
				case (kind)
					BLK_UNIFORM: v = $urandom_range(0, 4095);
					BLK_FLAT:    v = base;
					BLK_NARROW: begin
						v = base + $urandom_range(0, 16) - 8;
						v = (v < 0) ? 0 : (v > 4095) ? 4095 : v;
					end
					BLK_OUTLIER: v = (k == 3) ? 0 : (k == 7) ? 4095 : base;
					default:     v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
				endcase
				sample_q.push_back(SAMPLE_W'(v));
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (sample_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (block_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d samples and %0d block results", samples_taken, results_checked);
		$display("history ring wrapped %0d times, one long output stall", ring_wraps);
		if (errors == 0 && block_result_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#200000;
		$display("timeout with %0d results outstanding", block_result_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
